/* hdl/grid_maze_shortest_path_assert.svh */
// Assertion macros for the grid maze shortest path block.
// Used by gmsp_engine under hdl; needs signals named clock and reset in scope.
`ifndef GRID_MAZE_SHORTEST_PATH_ASSERT_SVH
`define GRID_MAZE_SHORTEST_PATH_ASSERT_SVH

// Check that prop holds at every clock edge outside reset.
`define GMSP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that ante implies cons on the next clock edge.
`define GMSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/gmsp_pkg.sv */
// Shared types, constants and neighbor functions of the grid maze router.
// No dependencies.
package gmsp_pkg;

   localparam int MAX_SIDE    = 128;
   localparam int SIDE_W      = 7;
   localparam int CELL_W      = 14;
   localparam int CELLS       = 16384;
   localparam int STACK_DEPTH = 16384;
   localparam int CNT_W       = 15;
   localparam int DIST_W      = 15;
   localparam int CFG_W       = 8;
   localparam int QUEUE_W     = CELL_W + DIST_W;

   localparam logic [CFG_W-1:0] SIDE_RESET = 8'd81;
   localparam logic [CFG_W-1:0] SIDE_MAX   = 8'd128;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_ROUTE = 2'd1,
      MODE_POP   = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BLOCKED  = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP_WAIT,
      S_RT_CHK,
      S_CLEAR,
      S_SEED,
      S_Q_RD,
      S_Q_WAIT,
      S_NB_RD,
      S_NB_CHK,
      S_T_RD,
      S_T_CHK,
      S_BT_PUSH,
      S_BT_NB,
      S_BT_CHK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [CNT_W-1:0]  path_length;
      logic [SIDE_W-1:0] step_x;
      logic [SIDE_W-1:0] step_y;
      logic              step_valid;
   } result_type;

   // True when the neighbor of cell c in direction k lies inside a w by h grid.
   function automatic logic nb_ok(input logic [CELL_W-1:0] c, input logic [1:0] k,
                                  input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      logic [CFG_W-1:0] x1;
      logic [CFG_W-1:0] y1;
      logic             ok;
      x1 = {1'b0, c[SIDE_W-1:0]} + 8'd1;
      y1 = {1'b0, c[CELL_W-1:SIDE_W]} + 8'd1;
      case (k)
         2'd0:    ok = x1 < w;
         2'd1:    ok = y1 < h;
         2'd2:    ok = c[SIDE_W-1:0] != '0;
         default: ok = c[CELL_W-1:SIDE_W] != '0;
      endcase
      return ok;
   endfunction

   // Cell index of the neighbor of c in direction k (+x, +y, -x, -y).
   function automatic logic [CELL_W-1:0] nb_cell(input logic [CELL_W-1:0] c,
                                                input logic [1:0] k);
      logic [SIDE_W-1:0] x;
      logic [SIDE_W-1:0] y;
      x = c[SIDE_W-1:0];
      y = c[CELL_W-1:SIDE_W];
      case (k)
         2'd0:    x = x + 7'd1;
         2'd1:    y = y + 7'd1;
         2'd2:    x = x - 7'd1;
         default: y = y - 7'd1;
      endcase
      return {y, x};
   endfunction

endpackage

/* hdl/grid_maze_shortest_path.sv */
// Top level of the grid maze shortest path router.
// Depends on gmsp_pkg and gmsp_engine.
// Usage:
//   req_* is a valid/ready channel. Mode load writes one wall bit, mode route
//   floods the maze from (cell_x, cell_y) and pushes the path to (target_x,
//   target_y) onto the step stack, mode pop returns the next step, nearest the
//   source first. Every transfer on req_* yields exactly one transfer on rsp_*.
//   csr_* writes grid_width (index 0) or grid_height (index 1) while idle.
// Operation:
//   A load or pop result is registered in the engine, then in the rsp_* output register;
//   the engine takes the next item only once its result has gone to that register.
//   A route runs a clearing pass over all 16384 entries of the distance memory, then
//   the flood, with a queue read and then a read/check pair for each of four neighbors
//   on the one-read-per-cycle distance and wall memories, then a backtrack that pushes
//   each path step. One item at a time.
// Reset: clears the stack count and sets both sizes to 81; memories are not cleared.
// Stall:
//   A result waits in the output register; the engine takes the next item and
//   holds its own finished result until the register is free.
module grid_maze_shortest_path (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [6:0]  req_cell_x,
   input  logic [6:0]  req_cell_y,
   input  logic        req_cell_wall,
   input  logic [6:0]  req_target_x,
   input  logic [6:0]  req_target_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [14:0] rsp_path_length,
   output logic [6:0]  rsp_step_x,
   output logic [6:0]  rsp_step_y,
   output logic        rsp_step_valid
);
   import gmsp_pkg::*;

   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   logic       out_free;
   logic       res_valid;
   result_type res;

   // output slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   gmsp_engine u_engine (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_cell_x(req_cell_x), .req_cell_y(req_cell_y), .req_cell_wall(req_cell_wall),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .out_free(out_free), .res_valid(res_valid), .res(res));

   // hold the result until the receiver takes the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_data_ff.status;
   assign rsp_path_length = rsp_data_ff.path_length;
   assign rsp_step_x      = rsp_data_ff.step_x;
   assign rsp_step_y      = rsp_data_ff.step_y;
   assign rsp_step_valid  = rsp_data_ff.step_valid;
endmodule

/* hdl/gmsp_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gmsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* hdl/gmsp_engine.sv */
// Sequencer of the maze router: loads, flood fill, backtrack and pops.
// Depends on gmsp_pkg, gmsp_ram and the assertion macro header.
`include "grid_maze_shortest_path_assert.svh"
module gmsp_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [0:0]                csr_index,
   input  logic [gmsp_pkg::CFG_W-1:0] csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_mode,
   input  logic [gmsp_pkg::SIDE_W-1:0] req_cell_x,
   input  logic [gmsp_pkg::SIDE_W-1:0] req_cell_y,
   input  logic                      req_cell_wall,
   input  logic [gmsp_pkg::SIDE_W-1:0] req_target_x,
   input  logic [gmsp_pkg::SIDE_W-1:0] req_target_y,
   input  logic                      out_free,
   output logic                      res_valid,
   output gmsp_pkg::result_type      res
);
   import gmsp_pkg::*;

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   width_ff, height_ff;
   logic [CFG_W-1:0]   w_eff, h_eff;
   logic [CELL_W-1:0]  src_ff, src_in, tgt_ff, tgt_in, cur_ff, cur_in;
   logic [DIST_W-1:0]  curd_ff, curd_in, want_ff, want_in;
   logic [CNT_W-1:0]   head_ff, head_in, tail_ff, tail_in, count_ff, count_in;
   logic [CNT_W-1:0]   clr_ff, clr_in;
   logic [1:0]         k_ff, k_in;
   result_type         res_ff, res_in;

   logic               wall_we, wall_wd, wall_rd;
   logic [CELL_W-1:0]  wall_wa, wall_ra;
   logic               dist_we;
   logic [CELL_W-1:0]  dist_wa, dist_ra;
   logic [DIST_W-1:0]  dist_wd, dist_rd;
   logic               q_we;
   logic [CELL_W-1:0]  q_wa, q_ra;
   logic [QUEUE_W-1:0] q_wd, q_rd;
   logic               stk_we;
   logic [CELL_W-1:0]  stk_wa, stk_ra, stk_wd, stk_rd;

   logic               accept, in_grid_cell, in_grid_tgt, nb_in;
   logic [CELL_W-1:0]  req_cell, req_tgt, nc;
   logic [DIST_W-1:0]  len_w;
   logic [CNT_W-1:0]   room_w;

   assign w_eff = (width_ff > SIDE_MAX) ? SIDE_MAX : width_ff;
   assign h_eff = (height_ff > SIDE_MAX) ? SIDE_MAX : height_ff;

   assign accept       = req_valid && req_ready;
   assign req_ready    = state_ff == S_IDLE;
   assign req_cell     = {req_cell_y, req_cell_x};
   assign req_tgt      = {req_target_y, req_target_x};
   assign in_grid_cell = ({1'b0, req_cell_x} < w_eff) && ({1'b0, req_cell_y} < h_eff);
   assign in_grid_tgt  = ({1'b0, req_target_x} < w_eff) && ({1'b0, req_target_y} < h_eff);
   assign nb_in        = nb_ok(cur_ff, k_ff, w_eff, h_eff);
   assign nc           = nb_cell(cur_ff, k_ff);
   assign len_w        = dist_rd - 15'd1;
   assign room_w       = CNT_W'(STACK_DEPTH) - count_ff;

   assign res_valid = (state_ff == S_DONE) && out_free;
   assign res       = res_ff;

   gmsp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall (
      .clock(clock), .we(wall_we), .waddr(wall_wa), .wdata(wall_wd),
      .raddr(wall_ra), .rdata(wall_rd));
   gmsp_ram #(.WIDTH(DIST_W), .DEPTH(CELLS)) u_dist (
      .clock(clock), .we(dist_we), .waddr(dist_wa), .wdata(dist_wd),
      .raddr(dist_ra), .rdata(dist_rd));
   gmsp_ram #(.WIDTH(QUEUE_W), .DEPTH(CELLS)) u_queue (
      .clock(clock), .we(q_we), .waddr(q_wa), .wdata(q_wd),
      .raddr(q_ra), .rdata(q_rd));
   gmsp_ram #(.WIDTH(CELL_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
      .raddr(stk_ra), .rdata(stk_rd));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_POP && count_ff != '0) begin
                  state_in = S_POP_WAIT;
               end else if (req_mode == MODE_ROUTE && in_grid_cell && in_grid_tgt) begin
                  state_in = (req_cell == req_tgt) ? S_CLEAR : S_RT_CHK;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_POP_WAIT: state_in = S_DONE;
         S_RT_CHK:   state_in = wall_rd ? S_DONE : S_CLEAR;
         S_CLEAR:    state_in = (clr_ff == CNT_W'(CELLS - 1)) ? S_SEED : S_CLEAR;
         S_SEED:     state_in = S_Q_RD;
         S_Q_RD:     state_in = (head_ff == tail_ff) ? S_T_RD : S_Q_WAIT;
         S_Q_WAIT:   state_in = S_NB_RD;
         S_NB_RD: begin
            if (nb_in) state_in = S_NB_CHK;
            else if (k_ff == 2'd3) state_in = S_Q_RD;
         end
         S_NB_CHK:   state_in = (k_ff == 2'd3) ? S_Q_RD : S_NB_RD;
         S_T_RD:     state_in = S_T_CHK;
         S_T_CHK: begin
            if (dist_rd == '0 || len_w > room_w) state_in = S_DONE;
            else state_in = S_BT_PUSH;
         end
         S_BT_PUSH:  state_in = (cur_ff == src_ff) ? S_DONE : S_BT_NB;
         S_BT_NB: begin
            if (nb_in) state_in = S_BT_CHK;
            else if (k_ff == 2'd3) state_in = S_DONE;
         end
         S_BT_CHK: begin
            if (dist_rd == want_ff) state_in = S_BT_PUSH;
            else if (k_ff == 2'd3) state_in = S_DONE;
            else state_in = S_BT_NB;
         end
         S_DONE:     state_in = out_free ? S_IDLE : S_DONE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      src_in = src_ff; tgt_in = tgt_ff; cur_in = cur_ff; curd_in = curd_ff;
      want_in = want_ff; head_in = head_ff; tail_in = tail_ff; count_in = count_ff;
      clr_in = clr_ff; k_in = k_ff; res_in = res_ff;
      wall_we = 1'b0; wall_wa = req_cell; wall_wd = req_cell_wall; wall_ra = req_tgt;
      dist_we = 1'b0; dist_wa = nc; dist_wd = curd_ff + 15'd1; dist_ra = nc;
      q_we = 1'b0; q_wa = tail_ff[CELL_W-1:0]; q_wd = {nc, curd_ff + 15'd1};
      q_ra = head_ff[CELL_W-1:0];
      stk_we = 1'b0; stk_wa = count_ff[CELL_W-1:0]; stk_wd = cur_ff;
      stk_ra = CELL_W'(count_ff - 15'd1);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in = '0;
               src_in = req_cell;
               tgt_in = req_tgt;
               clr_in = '0;
               case (req_mode)
                  MODE_LOAD: wall_we = in_grid_cell;
                  MODE_ROUTE: begin
                     if (!(in_grid_cell && in_grid_tgt)) res_in.status = ST_BLOCKED;
                  end
                  MODE_POP: begin
                     if (count_ff == '0) res_in.status = ST_EMPTY;
                     else count_in = count_ff - 15'd1;
                  end
                  default: ;
               endcase
            end
         end
         S_POP_WAIT: begin
            res_in.step_x     = stk_rd[SIDE_W-1:0];
            res_in.step_y     = stk_rd[CELL_W-1:SIDE_W];
            res_in.step_valid = 1'b1;
         end
         S_RT_CHK: begin
            if (wall_rd) res_in.status = ST_BLOCKED;
         end
         S_CLEAR: begin
            dist_we = 1'b1;
            dist_wa = clr_ff[CELL_W-1:0];
            dist_wd = '0;
            clr_in  = clr_ff + 15'd1;
         end
         S_SEED: begin
            dist_we = 1'b1;
            dist_wa = src_ff;
            dist_wd = 15'd1;
            q_we    = 1'b1;
            q_wa    = '0;
            q_wd    = {src_ff, 15'd1};
            head_in = '0;
            tail_in = 15'd1;
         end
         S_Q_RD: begin
            if (head_ff != tail_ff) head_in = head_ff + 15'd1;
         end
         S_Q_WAIT: begin
            cur_in  = q_rd[QUEUE_W-1:DIST_W];
            curd_in = q_rd[DIST_W-1:0];
            k_in    = '0;
         end
         S_NB_RD: begin
            wall_ra = nc;
            if (!nb_in) k_in = k_ff + 2'd1;
         end
         S_NB_CHK: begin
            if (!wall_rd && dist_rd == '0) begin
               dist_we = 1'b1;
               q_we    = 1'b1;
               tail_in = tail_ff + 15'd1;
            end
            k_in = k_ff + 2'd1;
         end
         S_T_RD: dist_ra = tgt_ff;
         S_T_CHK: begin
            if (dist_rd == '0) res_in.status = ST_BLOCKED;
            else if (len_w > room_w) res_in.status = ST_OVERFLOW;
            else begin
               res_in.path_length = len_w;
               cur_in  = tgt_ff;
               curd_in = dist_rd;
            end
         end
         S_BT_PUSH: begin
            if (cur_ff != src_ff) begin
               if (count_ff < CNT_W'(STACK_DEPTH)) begin
                  stk_we   = 1'b1;
                  count_in = count_ff + 15'd1;
               end
               want_in = curd_ff - 15'd1;
               k_in    = '0;
            end
         end
         S_BT_NB: begin
            if (!nb_in) k_in = k_ff + 2'd1;
         end
         S_BT_CHK: begin
            if (dist_rd == want_ff) begin
               cur_in  = nc;
               curd_in = want_ff;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         width_ff  <= SIDE_RESET;
         height_ff <= SIDE_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_WIDTH:  width_ff  <= csr_wdata;
               CSR_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      src_ff  <= src_in;
      tgt_ff  <= tgt_in;
      cur_ff  <= cur_in;
      curd_ff <= curd_in;
      want_ff <= want_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      clr_ff  <= clr_in;
      k_ff    <= k_in;
      res_ff  <= res_in;
   end

   `GMSP_ASSERT(a_count_bound, count_ff <= CNT_W'(STACK_DEPTH), "step stack count beyond depth")
   `GMSP_ASSERT(a_head_tail, (state_ff != S_Q_RD) || (head_ff <= tail_ff), "flood queue head passed tail")
   `GMSP_ASSERT(a_tail_bound, (state_ff != S_NB_CHK) || (tail_ff <= CNT_W'(CELLS)), "flood queue overrun")
   `GMSP_ASSERT_NEXT(a_accept_busy, accept, state_ff != S_IDLE, "engine idle right after a transfer")
endmodule

/* bench/grid_maze_shortest_path_tb.sv */
// Self-checking bench for the grid maze shortest path router.
// Needs gmsp_pkg and the router RTL; drives loads, routes and pops and checks every result.
`default_nettype none

module grid_maze_shortest_path_tb;
   import gmsp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = '0;
   logic [6:0]  req_cell_x = '0;
   logic [6:0]  req_cell_y = '0;
   logic        req_cell_wall = 1'b0;
   logic [6:0]  req_target_x = '0;
   logic [6:0]  req_target_y = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [14:0] rsp_path_length;
   logic [6:0]  rsp_step_x;
   logic [6:0]  rsp_step_y;
   logic        rsp_step_valid;

   grid_maze_shortest_path i_dut (.*);

   // Shadow copy of the router: wall bits, flood labels, step stack and sizes.
   logic             wall_bits [CELLS];
   int unsigned      flood_dist [CELLS];
   int unsigned      flood_fifo [CELLS];
   logic [CELL_W-1:0] step_cells [STACK_DEPTH];
   int unsigned      step_depth = 0;
   logic [7:0]       width_reg = SIDE_RESET;
   logic [7:0]       height_reg = SIDE_RESET;

   result_type       pending_results [$];
   int               error_count = 0;
   bit               calm = 1'b0;

   typedef struct {
      mode_type   mode;
      logic [6:0] x;
      logic [6:0] y;
      logic       wall;
      logic [6:0] tx;
      logic [6:0] ty;
      bit         typed;
      result_type want;
   } plan_row_type;

   // Directed items at the reset size of 81 by 81; none of them reads an unloaded cell.
   plan_row_type plan [8] = '{
      '{MODE_POP,   7'd0,   7'd0,   1'b0, 7'd0,   7'd0,   1'b1, '{ST_EMPTY, 0, 0, 0, 0}},
      '{MODE_NOP,   7'd127, 7'd127, 1'b1, 7'd127, 7'd127, 1'b1, '{ST_OK, 0, 0, 0, 0}},
      '{MODE_LOAD,  7'd127, 7'd0,   1'b1, 7'd0,   7'd0,   1'b1, '{ST_OK, 0, 0, 0, 0}},
      '{MODE_LOAD,  7'd80,  7'd80,  1'b1, 7'd0,   7'd0,   1'b1, '{ST_OK, 0, 0, 0, 0}},
      '{MODE_ROUTE, 7'd81,  7'd0,   1'b0, 7'd0,   7'd0,   1'b1, '{ST_BLOCKED, 0, 0, 0, 0}},
      '{MODE_ROUTE, 7'd0,   7'd0,   1'b0, 7'd0,   7'd127, 1'b1, '{ST_BLOCKED, 0, 0, 0, 0}},
      '{MODE_ROUTE, 7'd0,   7'd0,   1'b0, 7'd80,  7'd80,  1'b1, '{ST_BLOCKED, 0, 0, 0, 0}},
      '{MODE_POP,   7'd0,   7'd0,   1'b0, 7'd0,   7'd0,   1'b1, '{ST_EMPTY, 0, 0, 0, 0}}
   };

   // Clamp a size register to the largest side.
   function automatic int clamp_side(logic [7:0] v);
      return (v > SIDE_MAX) ? MAX_SIDE : int'(v);
   endfunction

   // Neighbor of cell c in direction k (+x, +y, -x, -y); 0 when it leaves the grid.
   function automatic bit hop(int c, int k, int w, int h, output int nc);
      int dx [4] = '{1, 0, -1, 0};
      int dy [4] = '{0, 1, 0, -1};
      int nx;
      int ny;
      nx = (c % MAX_SIDE) + dx[k];
      ny = (c / MAX_SIDE) + dy[k];
      nc = ny * MAX_SIDE + nx;
      return nx >= 0 && ny >= 0 && nx < w && ny < h;
   endfunction

   // Work out the result of one item and advance the shadow state.
   function automatic result_type route_result(mode_type m, logic [6:0] x, logic [6:0] y,
                                               logic wl, logic [6:0] tx, logic [6:0] ty);
      result_type r;
      int w, h, src, cur, head, tail, c, k, nc, nxt;
      int unsigned want;
      r = '0;
      w = clamp_side(width_reg);
      h = clamp_side(height_reg);
      case (m)
         MODE_LOAD: begin
            if (x < w && y < h) wall_bits[y * MAX_SIDE + x] = wl;
         end
         MODE_ROUTE: begin
            src = y * MAX_SIDE + x;
            cur = ty * MAX_SIDE + tx;
            if (x >= w || y >= h || tx >= w || ty >= h) begin
               r.status = ST_BLOCKED;
            end else if (cur != src && wall_bits[cur]) begin
               r.status = ST_BLOCKED;
            end else begin
               // Breadth-first flood from the source, source labeled 1.
               foreach (flood_dist[i]) flood_dist[i] = 0;
               flood_dist[src] = 1;
               flood_fifo[0] = src;
               head = 0;
               tail = 1;
               while (head < tail) begin
                  c = flood_fifo[head];
                  head++;
                  for (k = 0; k < 4; k++) begin
                     if (hop(c, k, w, h, nc) && !wall_bits[nc] && flood_dist[nc] == 0) begin
                        flood_dist[nc] = flood_dist[c] + 1;
                        flood_fifo[tail] = nc;
                        tail++;
                     end
                  end
               end
               if (flood_dist[cur] == 0) begin
                  r.status = ST_BLOCKED;
               end else if (flood_dist[cur] - 1 > STACK_DEPTH - step_depth) begin
                  r.status = ST_OVERFLOW;
               end else begin
                  r.path_length = CNT_W'(flood_dist[cur] - 1);
                  // Walk back from the target, first neighbor one label lower wins.
                  while (cur != src) begin
                     want = flood_dist[cur] - 1;
                     nxt = cur;
                     if (step_depth < STACK_DEPTH) begin
                        step_cells[step_depth] = CELL_W'(cur);
                        step_depth++;
                     end
                     for (k = 0; k < 4 && nxt == cur; k++)
                        if (hop(cur, k, w, h, nc) && flood_dist[nc] == want) nxt = nc;
                     if (nxt == cur) break;
                     cur = nxt;
                  end
               end
            end
         end
         MODE_POP: begin
            if (step_depth == 0) begin
               r.status = ST_EMPTY;
            end else begin
               step_depth--;
               r.step_x = step_cells[step_depth][SIDE_W-1:0];
               r.step_y = step_cells[step_depth][CELL_W-1:SIDE_W];
               r.step_valid = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // Send one item; hold valid and payload until the transfer, then log its expectation.
   task automatic issue(mode_type m, logic [6:0] x, logic [6:0] y, logic wl,
                        logic [6:0] tx, logic [6:0] ty, bit typed = 1'b0,
                        result_type want = '0);
      result_type r;
      if (!calm && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= m;
      req_cell_x    <= x;
      req_cell_y    <= y;
      req_cell_wall <= wl;
      req_target_x  <= tx;
      req_target_y  <= ty;
      do @(posedge clock); while (!req_ready);
      r = route_result(m, x, y, wl, tx, ty);
      pending_results.push_back(typed ? want : r);
   endtask

   // Drop valid and hold until every expected result is back, then let the engine settle.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Write both size registers; only called while idle.
   task automatic set_size(logic [7:0] w, logic [7:0] h);
      csr_we    <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
      width_reg  = w;
      height_reg = h;
      @(posedge clock);
   endtask

   // Load every cell of the grid in use, walls at about 30 percent.
   task automatic fill_grid;
      int w, h;
      w = clamp_side(width_reg);
      h = clamp_side(height_reg);
      for (int yy = 0; yy < h; yy++)
         for (int xx = 0; xx < w; xx++)
            issue(MODE_LOAD, 7'(xx), 7'(yy), $urandom_range(0, 99) < 30, 7'd0, 7'd0);
   endtask

   // Sink side: random back-pressure and in-order field checks.
   always @(posedge clock) begin
      result_type e;
      rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 33);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report("unexpected result, status", int'(rsp_status), 0);
         end else begin
            e = pending_results.pop_front();
            if (rsp_status != e.status)
               report("status", int'(rsp_status), int'(e.status));
            if (rsp_path_length != e.path_length)
               report("path_length", int'(rsp_path_length), int'(e.path_length));
            if (rsp_step_x != e.step_x)
               report("step_x", int'(rsp_step_x), int'(e.step_x));
            if (rsp_step_y != e.step_y)
               report("step_y", int'(rsp_step_y), int'(e.step_y));
            if (rsp_step_valid != e.step_valid)
               report("step_valid", int'(rsp_step_valid), int'(e.step_valid));
         end
      end
   end

   initial begin
      int w, h, r;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset size: empty pops, no-op, loads in and out of the grid, blocked routes.
      foreach (plan[i])
         issue(plan[i].mode, plan[i].x, plan[i].y, plan[i].wall, plan[i].tx, plan[i].ty,
               plan[i].typed, plan[i].want);
      drain();

      // 3 by 3 grid: one wall in the middle, routes around it, onto it and from it.
      set_size(8'd3, 8'd3);
      for (int yy = 0; yy < 3; yy++)
         for (int xx = 0; xx < 3; xx++)
            issue(MODE_LOAD, 7'(xx), 7'(yy), xx == 1 && yy == 1, 7'd0, 7'd0);
      issue(MODE_ROUTE, 7'd0, 7'd0, 1'b0, 7'd2, 7'd2);
      issue(MODE_ROUTE, 7'd1, 7'd0, 1'b0, 7'd1, 7'd0);
      issue(MODE_ROUTE, 7'd1, 7'd1, 1'b0, 7'd0, 7'd0);
      issue(MODE_ROUTE, 7'd0, 7'd0, 1'b0, 7'd1, 7'd1);
      repeat (8) issue(MODE_POP, 7'd0, 7'd0, 1'b0, 7'd0, 7'd0);
      drain();

      // Zero width: no cells at all; oversized height clamps.
      set_size(8'd0, 8'd200);
      issue(MODE_LOAD, 7'd0, 7'd0, 1'b1, 7'd0, 7'd0);
      issue(MODE_ROUTE, 7'd0, 7'd0, 1'b0, 7'd0, 7'd1);
      issue(MODE_POP, 7'd0, 7'd0, 1'b0, 7'd0, 7'd0);
      drain();

      // Random phases on small grids plus thin ones.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            2:       begin w = 6; h = 3; end
            3:       begin w = 3; h = 6; end
            default: begin w = $urandom_range(3, 4); h = $urandom_range(3, 4); end
         endcase
         set_size(8'(w), 8'(h));
         calm = (ph == 1);
         fill_grid();
         for (int n = 0; n < 5; n++) begin
            if (ph == 2 && n == 2) drain();
            r = $urandom_range(0, 99);
            if (r < 40) begin
               if ($urandom_range(0, 9) == 0)
                  issue(MODE_ROUTE, 7'($urandom), 7'($urandom), 1'($urandom),
                        7'($urandom), 7'($urandom));
               else
                  issue(MODE_ROUTE, 7'($urandom_range(0, w - 1)),
                        7'($urandom_range(0, h - 1)), 1'($urandom),
                        7'($urandom_range(0, w - 1)), 7'($urandom_range(0, h - 1)));
            end else if (r < 70) begin
               issue(MODE_POP, 7'($urandom), 7'($urandom), 1'($urandom),
                     7'($urandom), 7'($urandom));
            end else if (r < 90) begin
               issue(MODE_LOAD, 7'($urandom_range(0, w - 1)), 7'($urandom_range(0, h - 1)),
                     1'($urandom), 7'($urandom), 7'($urandom));
            end else if (r < 95) begin
               issue(MODE_LOAD, 7'($urandom), 7'($urandom), 1'($urandom),
                     7'($urandom), 7'($urandom));
            end else begin
               issue(MODE_NOP, 7'($urandom), 7'($urandom), 1'($urandom),
                     7'($urandom), 7'($urandom));
            end
         end
         calm = 1'b0;
         drain();
      end

      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Hang guard, several times the slowest legal run.
   initial begin
      #(64'd400_000_000);
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
